>>> rtl/avmp_pkg.sv
package avmp_pkg;

  localparam int MAG_W = 12;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  typedef logic [MAG_W-1:0] mag_t;

endpackage

>>> rtl/avmp_in_if.sv
interface avmp_in_if #(
  parameter int SAMPLE_BITS = 14
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_x;
  logic [SAMPLE_BITS-1:0] raw_y;
  logic [SAMPLE_BITS-1:0] raw_z;

  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

>>> rtl/avmp_out_if.sv
interface avmp_out_if #(
  parameter int SAMPLE_BITS = 14
);
  import avmp_pkg::*;

  logic                          valid;
  logic                          ready;
  mag_t                          magnitude;
  mag_t                          peak_magnitude;
  logic signed [SAMPLE_BITS-2:0] clip_x;
  logic signed [SAMPLE_BITS-2:0] clip_y;
  logic signed [SAMPLE_BITS-2:0] clip_z;

  modport source (output valid, output magnitude, output peak_magnitude,
                  output clip_x, output clip_y, output clip_z, input ready);
  modport sink   (input valid, input magnitude, input peak_magnitude,
                  input clip_x, input clip_y, input clip_z, output ready);
endinterface

>>> rtl/avmp_lane.sv
module avmp_lane #(
  parameter int SAMPLE_BITS = 14
) (
  input  logic                              clk,
  input  logic                              load,
  input  logic [SAMPLE_BITS-1:0]            raw,
  output logic signed [SAMPLE_BITS-2:0]     clip,
  output logic [2*(SAMPLE_BITS-3)-1:0]      sq
);
  import avmp_pkg::*;

  localparam int CW = SAMPLE_BITS - 1;
  localparam int QW = SAMPLE_BITS - 3;
  localparam int SW = 2 * QW;

  localparam logic [CW-1:0] POS_LIMIT = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NEG_LIMIT = {1'b1, {(CW-2){1'b0}}, 1'b1};

  logic          sign_bit;
  logic          oneg_bit;
  logic [CW-1:0] clip_c;
  logic [CW-1:0] abs_c;
  logic [QW-1:0] q;

  assign sign_bit = raw[SAMPLE_BITS-1];
  assign oneg_bit = raw[SAMPLE_BITS-2];

  always_comb begin
    priority if (!sign_bit && oneg_bit) begin
      clip_c = POS_LIMIT;
    end else if (sign_bit && !oneg_bit) begin
      clip_c = NEG_LIMIT;
    end else begin
      clip_c = raw[CW-1:0];
    end
  end

  // minus one g exactly gives 0x1000 here, still a valid unsigned magnitude
  assign abs_c = clip_c[CW-1] ? (~clip_c + CW'(1)) : clip_c;
  assign q     = abs_c[CW-1:2];

  always_ff @(posedge clk) begin
    if (load) begin
      clip <= clip_c;
      sq   <= SW'(q) * SW'(q);
    end
  end

endmodule

>>> rtl/avmp_isqrt.sv
module avmp_isqrt #(
  parameter int ROOT_W = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   operand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);
  import avmp_pkg::*;

  localparam int NW = 2 * ROOT_W;
  localparam int RW = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [NW-1:0]    opnd;
  logic [RW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;
  logic             fits;

  // one result bit per cycle, two operand bits brought down each step
  assign rem_sh = {rem[ROOT_W-1:0], opnd[NW-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(ROOT_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      opnd <= {opnd[NW-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

>>> rtl/accel_vector_magnitude_peak_unit.sv
// Three-axis accelerometer magnitude with peak hold.
//
// in_ch carries one sample word of three two's-complement axes; out_ch
// returns one word per sample: magnitude, running peak and the three
// axes clipped to one g. Both are valid/ready channels.
//
// Three axis lanes clip, rectify, quarter and square in parallel in the
// cycle a word is taken. The next cycle sums the squares and starts a
// restoring square root that settles one result bit per cycle. A new
// sample is taken only once the previous one has left the root unit, so
// the unit does not start a sample while another is still in work.
//
// The result sits in an output register; the next sample may be taken
// and worked on while it waits. If the receiver stalls longer, the
// finished root is held and no further sample is taken.
// Reset (synchronous) clears the peak to zero and empties the pipeline.
module accel_vector_magnitude_peak_unit #(
  parameter int SAMPLE_BITS = 14
) (
  input logic clk,
  input logic rst,
  avmp_in_if.sink    in_ch,
  avmp_out_if.source out_ch
);
  import avmp_pkg::*;

  localparam int CW     = SAMPLE_BITS - 1;
  localparam int SQ_W   = 2 * (SAMPLE_BITS - 3);
  localparam int ROOT_W = SAMPLE_BITS - 2;
  localparam int SUM_W  = 2 * ROOT_W;
  localparam int MX_W   = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_ROOT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic take;
  logic load_out;
  logic out_free;

  logic signed [CW-1:0] cx, cy, cz;
  logic [SQ_W-1:0]      sqx, sqy, sqz;
  logic [SUM_W-1:0]     sum;
  logic                 root_done;
  logic [ROOT_W-1:0]    root;
  logic [MX_W-1:0]      root_ext;
  mag_t                 mag;
  mag_t                 peak;
  mag_t                 peak_next;

  logic                 out_valid;

  assign in_ch.ready = (state == S_IDLE) && !rst;
  assign take        = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign load_out    = (state == S_ROOT) && root_done && out_free;

  avmp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk(clk), .load(take), .raw(in_ch.raw_x), .clip(cx), .sq(sqx)
  );
  avmp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk(clk), .load(take), .raw(in_ch.raw_y), .clip(cy), .sq(sqy)
  );
  avmp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
    .clk(clk), .load(take), .raw(in_ch.raw_z), .clip(cz), .sq(sqz)
  );

  assign sum = SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);

  avmp_isqrt #(.ROOT_W(ROOT_W)) u_isqrt (
    .clk(clk), .rst(rst), .start(state == S_SUM), .operand(sum),
    .done(root_done), .root(root)
  );

  // wider sample widths can exceed the 12-bit magnitude; saturate
  assign root_ext  = MX_W'(root);
  assign mag       = (root_ext > MX_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];
  assign peak_next = (mag > peak) ? mag : peak;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (take) state_next = S_SUM;
      S_SUM:   state_next = S_ROOT;
      S_ROOT:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        peak      <= peak_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.magnitude      <= mag;
      out_ch.peak_magnitude <= peak_next;
      out_ch.clip_x         <= cx;
      out_ch.clip_y         <= cy;
      out_ch.clip_z         <= cz;
    end
  end

  assign out_ch.valid = out_valid;

  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> peak >= $past(peak))
    else $error("peak hold decreased");

  a_peak_covers_mag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_ch.peak_magnitude >= out_ch.magnitude)
    else $error("peak below magnitude in result word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_ch.magnitude))
    else $error("pending result word overwritten");

  a_sum_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> state == S_SUM)
    else $error("accepted word not passed to root unit");

endmodule
